// ----- sv/sitds_pkg.sv -----
// ----------------------------------------------------------------------------
// sitds_pkg
// Shared widths, symbol codes and controller states for the signed integer
// to decimal symbol converter.
// ----------------------------------------------------------------------------
package sitds_pkg;

	localparam int VALUE_W           = 32;
	localparam int POS_W             = 4;
	localparam int SYM_W             = 4;
	localparam int BCD_W             = 4;
	localparam int DIGIT_LIMIT_DFLT  = 16;

	localparam logic [SYM_W-1:0] SYM_MINUS = 4'd10;
	localparam logic [SYM_W-1:0] SYM_TERM  = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_MINUS,
		ST_DIGIT,
		ST_TERM
	} sitds_state_t;

endpackage

// ----- sv/sitds_in_if.sv -----
// ----------------------------------------------------------------------------
// sitds_in_if
// Input channel: one signed value per transaction.
// ----------------------------------------------------------------------------
interface sitds_in_if
	import sitds_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// ----- sv/sitds_out_if.sv -----
// ----------------------------------------------------------------------------
// sitds_out_if
// Output channel: one symbol of the decimal string per transaction.
// ----------------------------------------------------------------------------
interface sitds_out_if
	import sitds_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position;
	logic [SYM_W-1:0] symbol;
	logic             last;

	modport source (output valid, output position, output symbol, output last, input ready);
	modport sink   (input valid, input position, input symbol, input last, output ready);
endinterface

// ----- sv/sitds_bin2bcd.sv -----
// ----------------------------------------------------------------------------
// sitds_bin2bcd
// Shift-and-add-3 binary to BCD converter, one input bit per cycle.
// ----------------------------------------------------------------------------
module sitds_bin2bcd
	import sitds_pkg::*;
#(
	parameter int DIGITS = DIGIT_LIMIT_DFLT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [VALUE_W-1:0]      mag,
	output logic                    done,
	output logic [DIGITS*BCD_W-1:0] bcd
);

	localparam int CNT_W = $clog2(VALUE_W);

	logic [VALUE_W-1:0]      sh_q;
	logic [DIGITS*BCD_W-1:0] bcd_q;
	logic [DIGITS*BCD_W-1:0] adj;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*BCD_W +: BCD_W] >= 4'd5)
				adj[i*BCD_W +: BCD_W] = bcd_q[i*BCD_W +: BCD_W] + 4'd3;
			else
				adj[i*BCD_W +: BCD_W] = bcd_q[i*BCD_W +: BCD_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VALUE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {adj[DIGITS*BCD_W-2:0], sh_q[VALUE_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ----- sv/signed_int_to_decimal_symbols_top.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_symbols_top
// Writes a signed 32-bit value as decimal text: optional minus, digits with
// no leading zeros, then a terminator carrying last.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                          | transaction
//  --------+-----+----------------------------------+------------------------
//  din     | in  | value[31:0] two's complement     | one value to convert
//  dout    | out | position[3:0] symbol[3:0] last   | one symbol of the text
//
// Steps per value: idle accept, BCD conversion, leading-zero scan, minus sign
//   when negative, one digit symbol per remaining digit, then the terminator.
// Reset: arst_n clears the controller and the output valid; no clearing pass.
// Stalls: a dout stall holds the symbol scan; din.ready is high only in idle,
//   and the next value is taken while the terminator still waits in dout.
//
module signed_int_to_decimal_symbols_top
	import sitds_pkg::*;
#(
	parameter int DIGIT_LIMIT = DIGIT_LIMIT_DFLT
) (
	input  logic         clk,
	input  logic         arst_n,
	sitds_in_if.sink     din,
	sitds_out_if.source  dout
);

	localparam int LEFT_W = $clog2(DIGIT_LIMIT + 1);
	localparam int BCDR_W = DIGIT_LIMIT * BCD_W;

	sitds_state_t state_q, state_d;

	logic [VALUE_W-1:0] raw;
	logic [VALUE_W-1:0] mag;
	logic               accept;
	logic               conv_done;
	logic [BCDR_W-1:0]  conv_bcd;

	logic               neg_q;
	logic [BCDR_W-1:0]  digits_q;
	logic [LEFT_W-1:0]  left_q;
	logic [POS_W-1:0]   pos_q;
	logic [BCD_W-1:0]   top_digit;
	logic               lead_zero;

	// output register
	logic               out_valid_q;
	logic [POS_W-1:0]   out_pos_q;
	logic [SYM_W-1:0]   out_sym_q;
	logic               out_last_q;
	logic               slot_free;

	// decoded controls
	logic               in_ready;
	logic               load;
	logic [SYM_W-1:0]   load_sym;
	logic               load_last;

	assign raw       = din.value;
	assign mag       = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
	assign accept    = din.valid && in_ready;
	assign slot_free = !out_valid_q || dout.ready;

	assign top_digit = digits_q[BCDR_W-1 -: BCD_W];
	// a leading zero is dropped unless it is the only digit left
	assign lead_zero = (top_digit == '0) && (left_q > LEFT_W'(1));

	sitds_bin2bcd #(
		.DIGITS (DIGIT_LIMIT)
	) u_bin2bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.done   (conv_done),
		.bcd    (conv_bcd)
	);

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (din.valid) state_d = ST_CONV;
			ST_CONV:  if (conv_done) state_d = ST_SKIP;
			ST_SKIP:  if (!lead_zero) state_d = neg_q ? ST_MINUS : ST_DIGIT;
			ST_MINUS: if (slot_free) state_d = ST_DIGIT;
			ST_DIGIT: if (slot_free && left_q == LEFT_W'(1)) state_d = ST_TERM;
			ST_TERM:  if (slot_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// ---- controller outputs ----
	always_comb begin
		in_ready  = 1'b0;
		load      = 1'b0;
		load_sym  = top_digit;
		load_last = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_CONV,
			ST_SKIP:  ;
			ST_MINUS: begin
				load     = slot_free;
				load_sym = SYM_MINUS;
			end
			ST_DIGIT: load = slot_free;
			ST_TERM: begin
				load      = slot_free;
				load_sym  = SYM_TERM;
				load_last = 1'b1;
			end
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (dout.ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath: sign, BCD scan register, digit count, string position
	always_ff @(posedge clk) begin
		if (accept)
			neg_q <= raw[VALUE_W-1];

		if (state_q == ST_CONV && conv_done) begin
			digits_q <= conv_bcd;
			left_q   <= LEFT_W'(DIGIT_LIMIT);
			pos_q    <= '0;
		end else if (state_q == ST_SKIP && lead_zero) begin
			digits_q <= {digits_q[BCDR_W-BCD_W-1:0], {BCD_W{1'b0}}};
			left_q   <= left_q - LEFT_W'(1);
		end else if (load && state_q == ST_DIGIT) begin
			digits_q <= {digits_q[BCDR_W-BCD_W-1:0], {BCD_W{1'b0}}};
			left_q   <= left_q - LEFT_W'(1);
			pos_q    <= pos_q + POS_W'(1);
		end else if (load && state_q == ST_MINUS) begin
			pos_q <= pos_q + POS_W'(1);
		end

		if (load) begin
			out_pos_q  <= pos_q;
			out_sym_q  <= load_sym;
			out_last_q <= load_last;
		end
	end

	assign din.ready     = in_ready;
	assign dout.valid    = out_valid_q;
	assign dout.position = out_pos_q;
	assign dout.symbol   = out_sym_q;
	assign dout.last     = out_last_q;

endmodule

// ----- sv/sitds_checker.sv -----
// ----------------------------------------------------------------------------
// sitds_checker
// Port-level checks on the decimal symbol converter, bound to the top level.
// ----------------------------------------------------------------------------
module sitds_checker
	import sitds_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [POS_W-1:0] out_position,
	input logic [SYM_W-1:0] out_symbol,
	input logic             out_last
);

	// a stalled symbol holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_symbol)
			&& $stable(out_position) && $stable(out_last))
		else $error("dout changed while stalled");

	// last marks the terminator and nothing else
	a_last_term: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_symbol == SYM_TERM)))
		else $error("last and terminator disagree");

	// a minus sign only opens the string
	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_symbol == SYM_MINUS |-> out_position == '0)
		else $error("minus sign away from position 0");

	// the terminator never stands alone at position 0
	a_term_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_position != '0)
		else $error("terminator without digits");

	// one value at a time: no transaction right after an accepted one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while converting");

endmodule

bind signed_int_to_decimal_symbols_top sitds_checker u_sitds_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (din.valid),
	.in_ready     (din.ready),
	.out_valid    (dout.valid),
	.out_ready    (dout.ready),
	.out_position (dout.position),
	.out_symbol   (dout.symbol),
	.out_last     (dout.last)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives signed 32-bit values into the decimal symbol converter and checks
// every symbol it writes (position, code, last) against a local prediction.
// ----------------------------------------------------------------------------
module testbench;
	import sitds_pkg::*;

	// Same digit limit as the default build of the block.
	localparam int DIGIT_LIMIT  = DIGIT_LIMIT_DFLT;
	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 6;
	// Quiet cycles after the last symbol: roughly one full conversion.
	localparam int DRAIN_CYCLES = 40 + DIGIT_LIMIT;
	// The slowest honest run (about 275 values, up to 12 symbols each behind a
	// heavily stalled sink) stays well under this limit; take plenty of margin.
	localparam int CYCLE_LIMIT  = 600000;
	localparam int REPORT_MAX   = 10;

	// One symbol the block should write.
	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [SYM_W-1:0] symbol;
		logic             last;
	} symbol_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	sitds_in_if  din_if ();
	sitds_out_if dout_if ();

	signed_int_to_decimal_symbols_top #(
		.DIGIT_LIMIT (DIGIT_LIMIT)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if.sink),
		.dout   (dout_if.source)
	);

	// Values waiting to be offered, and symbols still owed by the block.
	logic [VALUE_W-1:0] values_to_send [$];
	symbol_rec_t        symbols_due [$];

	// Idle percentages for each side, changed between phases.
	int unsigned send_idle_pct = 0;
	int unsigned sink_idle_pct = 0;

	int errors        = 0;
	int values_taken  = 0;
	int symbols_seen  = 0;
	int negatives     = 0;
	int longest_run   = 0;
	int cycle_count   = 0;
	int run_len       = 0;

	// ------------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------------
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Reset is held from time zero; the driver and sink blocks set their own
	// outputs while it is low.
	initial begin
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// ------------------------------------------------------------------------
	// Predictor: expected symbol run for one accepted value.
	// Magnitude is taken unsigned, so the most negative value comes out as
	// 2147483648 rather than overflowing. Digits are peeled off least
	// significant first and then written back most significant first.
	// ------------------------------------------------------------------------
	function automatic void predict_symbols(input logic [VALUE_W-1:0] raw);
		logic [VALUE_W-1:0] mag;
		logic [BCD_W-1:0]   digit_buf [DIGIT_LIMIT];
		int                 n_digits;
		int                 pos;
		mag      = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
		n_digits = 0;
		do begin
			digit_buf[n_digits] = BCD_W'(mag % 32'd10);
			mag                 = mag / 32'd10;
			n_digits++;
		end while (mag != '0 && n_digits < DIGIT_LIMIT);
		pos = 0;
		if (raw[VALUE_W-1]) begin
			symbols_due.push_back('{position: POS_W'(pos), symbol: SYM_MINUS, last: 1'b0});
			pos++;
		end
		for (int i = n_digits - 1; i >= 0; i--) begin
			symbols_due.push_back('{position: POS_W'(pos), symbol: SYM_W'(digit_buf[i]),
				last: 1'b0});
			pos++;
		end
		symbols_due.push_back('{position: POS_W'(pos), symbol: SYM_TERM, last: 1'b1});
	endfunction

	// ------------------------------------------------------------------------
	// Driver: offers the next pending value when the slot is free. valid and
	// value each take one nonblocking write per edge; a held valid is never
	// dropped and raised in the same step.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		logic accepted;
		logic slot_free;
		if (!arst_n) begin
			din_if.valid <= 1'b0;
			din_if.value <= '0;
		end else begin
			accepted  = din_if.valid && din_if.ready;
			slot_free = !din_if.valid || accepted;
			if (accepted) begin
				predict_symbols(din_if.value);
				values_taken++;
				if (din_if.value[VALUE_W-1])
					negatives++;
			end
			if (slot_free) begin
				if (values_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					din_if.valid <= 1'b1;
					din_if.value <= values_to_send.pop_front();
				end else begin
					din_if.valid <= 1'b0;
				end
			end
		end
	end

	// Sink back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
		end else begin
			dout_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: each symbol transaction is matched against the oldest
	// expectation, field by field.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		symbol_rec_t want;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			symbols_seen++;
			run_len++;
			if (dout_if.last) begin
				if (run_len > longest_run)
					longest_run = run_len;
				run_len = 0;
			end
			if (symbols_due.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected symbol: pos %0d sym %0d last %0b",
						dout_if.position, dout_if.symbol, dout_if.last);
			end else begin
				want = symbols_due.pop_front();
				if (dout_if.position !== want.position || dout_if.symbol !== want.symbol
						|| dout_if.last !== want.last) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display({"symbol %0d wrong: want pos %0d sym %0d last %0b,",
							" got pos %0d sym %0d last %0b"},
							symbols_seen - 1, want.position, want.symbol, want.last,
							dout_if.position, dout_if.symbol, dout_if.last);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Mix of fully random words, random digit counts, values around powers
	// of ten and single digits, with random sign.
	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] p;
		int unsigned        d;
		p = 32'd1;
		case ($urandom_range(0, 3))
			0: begin
				return VALUE_W'($urandom);
			end
			1: begin
				d = $urandom_range(1, 9);
				repeat (d) p = p * 32'd10;
				mag = VALUE_W'($urandom_range(0, p - 1));
			end
			2: begin
				d = $urandom_range(0, 9);
				repeat (d) p = p * 32'd10;
				mag = p + VALUE_W'($urandom_range(0, 2)) - 32'd1;
			end
			default: begin
				mag = VALUE_W'($urandom_range(0, 9));
			end
		endcase
		return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
	endfunction

	// Sender holds off here until the block has handed back every symbol.
	task automatic wait_all_done();
		while (values_to_send.size() != 0 || din_if.valid || symbols_due.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned phase_pct [3][2];
		int          phase_len [3];
		// sender idle, sink idle per phase; the last phase has no idling
		phase_pct[0] = '{36, 87};
		phase_pct[1] = '{87, 36};
		phase_pct[2] = '{0, 0};
		phase_len    = '{84, 83, 83};

		send_idle_pct = phase_pct[0][0];
		sink_idle_pct = phase_pct[0][1];

		// Directed: zero, single digits, the length boundaries at 10, 100 and
		// 1000000000, both extremes including the most negative value, alternating bits.
		values_to_send.push_back(32'd0);
		values_to_send.push_back(32'd1);
		values_to_send.push_back(-32'sd1);
		values_to_send.push_back(32'd9);
		values_to_send.push_back(-32'sd9);
		values_to_send.push_back(32'd10);
		values_to_send.push_back(-32'sd10);
		values_to_send.push_back(32'd99);
		values_to_send.push_back(32'd100);
		values_to_send.push_back(32'd999999999);
		values_to_send.push_back(32'd1000000000);
		values_to_send.push_back(-32'sd1000000000);
		values_to_send.push_back(32'd1234567890);
		values_to_send.push_back(32'h7FFF_FFFF);
		values_to_send.push_back(32'h8000_0000);
		values_to_send.push_back(32'h8000_0001);
		values_to_send.push_back(32'h5555_5555);
		values_to_send.push_back(32'hAAAA_AAAA);
		values_to_send.push_back(32'hFFFF_FFFE);
		@(posedge arst_n);
		wait_all_done();

		// Random phases; each starts only once the previous one has fully
		// drained, which also gives the sender a hold-off with nothing owed.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = phase_pct[ph][0];
			sink_idle_pct = phase_pct[ph][1];
			for (int n = 0; n < phase_len[ph]; n++)
				values_to_send.push_back(pick_value());
			wait_all_done();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (symbols_due.size() != 0) begin
			errors += symbols_due.size();
			$display("%0d symbols never arrived", symbols_due.size());
		end

		$display("converted %0d values (%0d negative) into %0d symbols, longest string %0d",
			values_taken, negatives, symbols_seen, longest_run);
		$display("ran %0d cycles under sender/sink idling in both orders and without; %0d errors",
			cycle_count, errors);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
